/* rtl/core/msb_pkg.sv */
package msb_pkg;

    localparam int SCREEN_W   = 84;
    localparam int SCREEN_H   = 48;
    localparam int PAGES      = (SCREEN_H + 7) / 8;
    localparam int STORE_SIZE = SCREEN_W * PAGES;
    localparam int AW         = $clog2(STORE_SIZE);

    localparam logic [2:0] CMD_FILL  = 3'd0;
    localparam logic [2:0] CMD_WRITE = 3'd1;
    localparam logic [2:0] CMD_READ  = 3'd2;
    localparam logic [2:0] CMD_SET   = 3'd3;
    localparam logic [2:0] CMD_GET   = 3'd4;
    localparam logic [2:0] CMD_BLIT  = 3'd5;

    localparam logic [2:0] REG_POS_X = 3'd0;
    localparam logic [2:0] REG_POS_Y = 3'd1;
    localparam logic [2:0] REG_WIN_X = 3'd2;
    localparam logic [2:0] REG_WIN_Y = 3'd3;
    localparam logic [2:0] REG_WIN_W = 3'd4;
    localparam logic [2:0] REG_WIN_H = 3'd5;
    localparam logic [2:0] REG_SCALE = 3'd6;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] col;
        logic [7:0] row;
        logic [7:0] value;
        logic [7:0] mask;
        logic [8:0] addr;
    } cmd_t;

    typedef struct packed {
        logic [7:0] raw_byte;
        logic [7:0] panel_byte;
        logic       pixel;
        logic       in_range;
    } res_t;

    typedef struct packed {
        logic signed [8:0] pos_x;
        logic signed [8:0] pos_y;
        logic [7:0]        win_x;
        logic [7:0]        win_y;
        logic [7:0]        win_w;
        logic [7:0]        win_h;
        logic [3:0]        scale;
    } cfg_t;

    function automatic logic [7:0] reverse8(input logic [7:0] b);
        logic [7:0] r;
        for (int i = 0; i < 8; i++)
        begin
            r[7 - i] = b[i];
        end
        return r;
    endfunction

endpackage

/* rtl/core/msb_ram.sv */
module msb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 504
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* rtl/core/msb_cfg.sv */
module msb_cfg (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [2:0]    cfg_index,
    input  logic [8:0]    cfg_data,
    output msb_pkg::cfg_t cfg
);
    import msb_pkg::*;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{pos_x: 9'sd0, pos_y: 9'sd0, win_x: 8'd0, win_y: 8'd0,
                         win_w: 8'd255, win_h: 8'd255, scale: 4'd1};
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_POS_X: cfg_reg.pos_x <= cfg_data;
                REG_POS_Y: cfg_reg.pos_y <= cfg_data;
                REG_WIN_X: cfg_reg.win_x <= cfg_data[7:0];
                REG_WIN_Y: cfg_reg.win_y <= cfg_data[7:0];
                REG_WIN_W: cfg_reg.win_w <= cfg_data[7:0];
                REG_WIN_H: cfg_reg.win_h <= cfg_data[7:0];
                REG_SCALE: cfg_reg.scale <= cfg_data[3:0];
                default: ;
            endcase
        end
    end
endmodule

/* rtl/core/mono_sprite_blitter_page_framebuffer_top.sv */
// Page-organized 84x48 monochrome framebuffer with sprite blitter.
// Command channel: an item is taken when start is high and busy is low.
// busy rises the cycle after acceptance and stays high until the item is done.
// Results (read byte, get pixel) appear for one cycle with done high, registered
// after the S_RD, S_WAIT and S_MOD states; the receiver must take them then.
// Config channel: cfg_valid/cfg_ready with register index and data; ready is
// always high, writes are meant only while the block is idle.
// Steps: write passes S_RD and a one-byte S_FILL; set, read and get pass S_RD,
// S_WAIT and S_MOD; an off-screen set or out-of-range write ends after S_RD;
// unused codes leave busy low; fill writes all bytes, one byte per cycle.
// Blit: each of the 8 sprite bits is checked in S_BIT; a drawn bit then
// sweeps its scale x scale block pixel by pixel, each on-screen pixel a
// read-modify-write through S_PIX, S_WAIT and S_MOD on the frame RAM (one
// read and one write port) and each off-screen pixel only S_PIX.
// After reset the frame RAM is cleared by a sweep of all 504 bytes; busy is
// high meanwhile. Configuration writes are taken during the sweep.
module mono_sprite_blitter_page_framebuffer_top (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  msb_pkg::cmd_t cmd_in,
    output logic          done,
    output msb_pkg::res_t result,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [2:0]    cfg_index,
    input  logic [8:0]    cfg_data
);
    import msb_pkg::*;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_FILL  = 4'd2;
    localparam logic [3:0] S_RD    = 4'd3;
    localparam logic [3:0] S_WAIT  = 4'd4;
    localparam logic [3:0] S_MOD   = 4'd5;
    localparam logic [3:0] S_BIT   = 4'd6;
    localparam logic [3:0] S_PIX   = 4'd7;

    cfg_t cfg;
    msb_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .cfg      (cfg)
    );

    logic [3:0]  state_reg, state_next;
    cmd_t        c_reg;
    logic [AW-1:0] ptr_reg;
    logic [2:0]  k_reg;
    logic [3:0]  l_reg, m_reg;
    logic signed [13:0] bx_reg, by_reg;   // scaled block origin
    logic [2:0]  bit_reg;                 // bit within byte for RMW
    logic        col_reg;                 // colour for RMW
    logic        blit_reg;                // RMW belongs to a blit
    logic        rd_res_reg;              // RMW is really a read/get
    logic        done_reg;
    res_t        res_reg;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [7:0]    wdata, rdata;

    msb_ram #(.WIDTH(8), .DEPTH(STORE_SIZE)) u_ram (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rdata)
    );

    // blit bit check for current k
    logic [10:0] src_y;
    logic        in_win, on_scr;
    logic signed [10:0] tx;
    logic signed [12:0] ty;
    logic signed [13:0] tx_s, ty_s;
    always_comb
    begin
        src_y  = {c_reg.row, k_reg};
        in_win = ({1'b0, c_reg.col} >= {1'b0, cfg.win_x}) &&
                 ({1'b0, c_reg.col} < ({1'b0, cfg.win_x} + {1'b0, cfg.win_w})) &&
                 (src_y >= {3'b0, cfg.win_y}) &&
                 (src_y < ({3'b0, cfg.win_y} + {3'b0, cfg.win_h}));
        tx = 11'(cfg.pos_x) + $signed({3'b0, c_reg.col}) - $signed({3'b0, cfg.win_x});
        ty = 13'(cfg.pos_y) + $signed({2'b0, src_y}) - $signed({5'b0, cfg.win_y});
        on_scr = (tx >= 0) && (tx < SCREEN_W) && (ty >= 0) && (ty < SCREEN_H);
        tx_s = 14'(tx) * 14'($signed({1'b0, cfg.scale}));
        ty_s = 14'(ty) * 14'($signed({1'b0, cfg.scale}));
    end

    // current pixel of the block sweep
    logic signed [14:0] px, py;
    logic px_ok;
    always_comb
    begin
        px = 15'(bx_reg) + 15'($signed({1'b0, l_reg}));
        py = 15'(by_reg) + 15'($signed({1'b0, m_reg}));
        px_ok = (px >= 0) && (px < SCREEN_W) && (py >= 0) && (py < SCREEN_H);
    end

    logic [AW-1:0] a_reg;
    logic [AW-1:0] set_addr, pix_addr;
    logic          set_ok;
    always_comb
    begin
        set_ok   = (c_reg.col < SCREEN_W) && (c_reg.row < SCREEN_H);
        set_addr = AW'(32'(c_reg.row >> 3) * SCREEN_W + 32'(c_reg.col));
        pix_addr = AW'(32'(py[7:3]) * SCREEN_W + 32'(px[7:0]));
    end

    logic [7:0] mod_byte;
    always_comb
    begin
        mod_byte = rdata;
        mod_byte[bit_reg] = col_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        we    = 1'b0;
        waddr = ptr_reg;
        wdata = 8'd0;
        raddr = a_reg;
        case (state_reg)
            S_CLEAR:
            begin
                we = 1'b1;
                if (32'(ptr_reg) == STORE_SIZE - 1) state_next = S_IDLE;
            end
            S_FILL:
            begin
                we    = 1'b1;
                wdata = c_reg.value;
                if (32'(ptr_reg) == STORE_SIZE - 1) state_next = S_IDLE;
            end
            S_MOD:
            begin
                we    = !rd_res_reg;
                waddr = a_reg;
                wdata = mod_byte;
                state_next = blit_reg ? S_PIX : S_IDLE;
            end
            default: ;
        endcase
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            ptr_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_CLEAR, S_FILL:
                begin
                    ptr_reg <= (32'(ptr_reg) == STORE_SIZE - 1) ? '0 : ptr_reg + 1'b1;
                    // single-byte write: stop the fill sweep after one byte
                    state_reg <= (state_reg == S_FILL && c_reg.cmd == CMD_WRITE) ?
                                 S_IDLE : state_next;
                end
                S_IDLE:
                begin
                    if (start)
                    begin
                        c_reg      <= cmd_in;
                        ptr_reg    <= '0;
                        blit_reg   <= 1'b0;
                        rd_res_reg <= 1'b0;
                        k_reg      <= '0;
                        case (cmd_in.cmd)
                            CMD_FILL:  state_reg <= S_FILL;
                            CMD_WRITE, CMD_READ, CMD_SET, CMD_GET: state_reg <= S_RD;
                            CMD_BLIT:
                            begin
                                blit_reg  <= 1'b1;
                                state_reg <= S_BIT;
                            end
                            default: ;
                        endcase
                    end
                end
                S_RD:
                begin
                    // decode simple commands into address, bit and colour
                    state_reg <= S_WAIT;
                    case (c_reg.cmd)
                        CMD_WRITE:
                        begin
                            if (32'(c_reg.addr) < STORE_SIZE)
                            begin
                                ptr_reg <= c_reg.addr[AW-1:0];
                                state_reg <= S_FILL;  // reused as a one-byte write
                            end
                            else
                            begin
                                state_reg <= S_IDLE;
                            end
                        end
                        CMD_READ:
                        begin
                            a_reg <= (32'(c_reg.addr) < STORE_SIZE) ? c_reg.addr[AW-1:0] : '0;
                            rd_res_reg <= 1'b1;
                        end
                        CMD_GET:
                        begin
                            a_reg <= set_ok ? set_addr : '0;
                            bit_reg <= c_reg.row[2:0];
                            rd_res_reg <= 1'b1;
                        end
                        default:
                        begin
                            a_reg   <= set_addr;
                            bit_reg <= c_reg.row[2:0];
                            col_reg <= c_reg.value[0];
                            if (!set_ok) state_reg <= S_IDLE;
                        end
                    endcase
                end
                S_WAIT:
                begin
                    state_reg <= S_MOD;
                end
                S_MOD:
                begin
                    state_reg <= state_next;
                    if (rd_res_reg)
                    begin
                        done_reg <= 1'b1;
                        if (c_reg.cmd == CMD_READ)
                        begin
                            res_reg.raw_byte   <= (32'(c_reg.addr) < STORE_SIZE) ? rdata : 8'd0;
                            res_reg.panel_byte <= (32'(c_reg.addr) < STORE_SIZE) ?
                                                  reverse8(rdata) : 8'd0;
                            res_reg.pixel      <= 1'b0;
                            res_reg.in_range   <= 1'b0;
                        end
                        else
                        begin
                            res_reg.raw_byte   <= 8'd0;
                            res_reg.panel_byte <= 8'd0;
                            res_reg.pixel      <= set_ok & rdata[bit_reg];
                            res_reg.in_range   <= set_ok;
                        end
                    end
                    if (blit_reg)
                    begin
                        // advance block sweep
                        if (l_reg == cfg.scale - 1'b1)
                        begin
                            l_reg <= '0;
                            if (m_reg == cfg.scale - 1'b1)
                            begin
                                state_reg <= (k_reg == 3'd7) ? S_IDLE : S_BIT;
                                k_reg <= k_reg + 1'b1;
                            end
                            else
                            begin
                                m_reg <= m_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            l_reg <= l_reg + 1'b1;
                        end
                    end
                end
                S_BIT:
                begin
                    l_reg  <= '0;
                    m_reg  <= '0;
                    bx_reg <= tx_s;
                    by_reg <= ty_s;
                    col_reg <= c_reg.value[k_reg];
                    if (in_win && on_scr && c_reg.mask[k_reg] && cfg.scale != 4'd0)
                    begin
                        state_reg <= S_PIX;
                    end
                    else
                    begin
                        state_reg <= (k_reg == 3'd7) ? S_IDLE : S_BIT;
                        k_reg <= k_reg + 1'b1;
                    end
                end
                S_PIX:
                begin
                    // one pixel of the block; off-screen pixels skip the RMW
                    a_reg   <= pix_addr;
                    bit_reg <= py[2:0];
                    if (px_ok)
                    begin
                        state_reg <= S_WAIT;
                    end
                    else if (l_reg == cfg.scale - 1'b1)
                    begin
                        l_reg <= '0;
                        if (m_reg == cfg.scale - 1'b1)
                        begin
                            state_reg <= (k_reg == 3'd7) ? S_IDLE : S_BIT;
                            k_reg <= k_reg + 1'b1;
                        end
                        else
                        begin
                            m_reg <= m_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        l_reg <= l_reg + 1'b1;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
